FILE: rtl/bta_pkg.sv
// ----------------------------------------------------------------------------
// bta_pkg
// Shared types, constants and the CORDIC arctangent table for the bearing
// triangulation block.
// ----------------------------------------------------------------------------
package bta_pkg;

    // Default store depth
    localparam int MAX_BEARINGS_DEF = 16;

    // CORDIC: Q2.30 gain-compensated start value and step count
    localparam int                 CORDIC_STEPS = 30;
    localparam logic signed [32:0] CORDIC_GAIN  = 33'sh026DD3B6A;

    // Direction vector component width (Q2.30, range +/-2^30 inclusive)
    localparam int DIR_W  = 32;
    // Shared multiplier operand and product widths
    localparam int MUL_AW = 36;
    localparam int MUL_BW = 32;
    localparam int PROD_W = MUL_AW + MUL_BW;
    // Divider widths
    localparam int DVD_W  = PROD_W;
    localparam int DVS_W  = 33;
    localparam int QUO_W  = DVD_W + 1;

    localparam logic [30:0] THR_RESET = 31'd1074;

    // One observation
    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic        [15:0] bearing;
        logic               last;
    } t_obs;

    // One result
    typedef struct packed {
        logic signed [31:0] src_x;
        logic signed [31:0] src_y;
        logic               found;
        logic        [6:0]  pair_count;
    } t_res;

    // Start / done pair for the iterative units
    typedef struct packed {
        logic start;
        logic done;
    } t_unit_ctl;

    // atan(2^-i) in units of 2^-32 turn
    function automatic logic [31:0] atan_turn(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:    v = 32'h20000000;
            5'd1:    v = 32'h12E4051E;
            5'd2:    v = 32'h09FB385B;
            5'd3:    v = 32'h051111D4;
            5'd4:    v = 32'h028B0D43;
            5'd5:    v = 32'h0145D7E1;
            5'd6:    v = 32'h00A2F61E;
            5'd7:    v = 32'h00517C55;
            5'd8:    v = 32'h0028BE53;
            5'd9:    v = 32'h00145F2F;
            5'd10:   v = 32'h000A2F98;
            5'd11:   v = 32'h000517CC;
            5'd12:   v = 32'h00028BE6;
            5'd13:   v = 32'h000145F3;
            5'd14:   v = 32'h0000A2FA;
            5'd15:   v = 32'h0000517D;
            5'd16:   v = 32'h000028BE;
            5'd17:   v = 32'h0000145F;
            5'd18:   v = 32'h00000A30;
            5'd19:   v = 32'h00000518;
            5'd20:   v = 32'h0000028C;
            5'd21:   v = 32'h00000146;
            5'd22:   v = 32'h000000A3;
            5'd23:   v = 32'h00000051;
            5'd24:   v = 32'h00000029;
            5'd25:   v = 32'h00000014;
            5'd26:   v = 32'h0000000A;
            5'd27:   v = 32'h00000005;
            5'd28:   v = 32'h00000003;
            5'd29:   v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

FILE: rtl/bta_cordic.sv
// ----------------------------------------------------------------------------
// bta_cordic
// Iterative rotation-mode CORDIC: one micro-rotation per cycle, giving the
// Q2.30 cosine and sine of a 16-bit binary angle.
// ----------------------------------------------------------------------------
module bta_cordic (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  bta_pkg::t_unit_ctl                  i_ctl,
    input  logic [15:0]                         i_angle,
    output logic                                o_done,
    output logic signed [bta_pkg::DIR_W-1:0]    o_cos,
    output logic signed [bta_pkg::DIR_W-1:0]    o_sin
);

    localparam logic signed [32:0] ONE_Q30 = 33'sh040000000;
    localparam int DIR_W_T = bta_pkg::DIR_W;

    logic               r_busy, r_done, r_flip;
    logic [4:0]         r_step;
    logic signed [32:0] r_x, r_y, r_z;
    logic signed [32:0] sx, sy, at, fx, fy;
    logic [15:0]        ang_f;
    logic               flip;

    // Quadrant fold: second and third quarter turns rotate by half a turn
    assign flip  = (i_angle[15:14] == 2'b01) || (i_angle[15:14] == 2'b10);
    assign ang_f = flip ? (i_angle ^ 16'h8000) : i_angle;

    assign sx = r_y >>> r_step;
    assign sy = r_x >>> r_step;
    assign at = {1'b0, bta_pkg::atan_turn(r_step)};

    // Micro-rotation sequencing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start && !r_busy) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                if (r_step == 5'(bta_pkg::CORDIC_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_step <= r_step + 5'd1;
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_ctl.start && !r_busy) begin
            r_x    <= bta_pkg::CORDIC_GAIN;
            r_y    <= '0;
            r_z    <= {ang_f[15], ang_f, 16'h0000};
            r_flip <= flip;
        end else if (r_busy) begin
            if (!r_z[32]) begin
                r_x <= r_x - sx;
                r_y <= r_y + sy;
                r_z <= r_z - at;
            end else begin
                r_x <= r_x + sx;
                r_y <= r_y - sy;
                r_z <= r_z + at;
            end
        end
    end

    // Unfold and saturate to +/-1.0
    assign fx = r_flip ? -r_x : r_x;
    assign fy = r_flip ? -r_y : r_y;

    always_comb begin
        if (fx > ONE_Q30)       o_cos = DIR_W_T'(ONE_Q30);
        else if (fx < -ONE_Q30) o_cos = DIR_W_T'(-ONE_Q30);
        else                    o_cos = DIR_W_T'(fx);
        if (fy > ONE_Q30)       o_sin = DIR_W_T'(ONE_Q30);
        else if (fy < -ONE_Q30) o_sin = DIR_W_T'(-ONE_Q30);
        else                    o_sin = DIR_W_T'(fy);
    end

    assign o_done = r_done;

endmodule

FILE: rtl/bta_mul.sv
// ----------------------------------------------------------------------------
// bta_mul
// Shared signed multiplier with a registered product and load enable.
// ----------------------------------------------------------------------------
module bta_mul (
    input  logic                                 i_clk,
    input  logic                                 i_en,
    input  logic signed [bta_pkg::MUL_AW-1:0]    i_a,
    input  logic signed [bta_pkg::MUL_BW-1:0]    i_b,
    output logic signed [bta_pkg::PROD_W-1:0]    o_p
);

    logic signed [bta_pkg::PROD_W-1:0] r_p;

    // Product register, held while not enabled
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= bta_pkg::PROD_W'(i_a) * bta_pkg::PROD_W'(i_b);
        end
    end

    assign o_p = r_p;

endmodule

FILE: rtl/bta_div.sv
// ----------------------------------------------------------------------------
// bta_div
// Iterative signed divider, one quotient bit per cycle, truncating toward
// zero.
// ----------------------------------------------------------------------------
module bta_div (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  bta_pkg::t_unit_ctl                   i_ctl,
    input  logic signed [bta_pkg::DVD_W-1:0]     i_dividend,
    input  logic signed [bta_pkg::DVS_W-1:0]     i_divisor,
    output logic                                 o_done,
    output logic signed [bta_pkg::QUO_W-1:0]     o_quot
);

    localparam int DW = bta_pkg::DVD_W;
    localparam int VW = bta_pkg::DVS_W - 1;
    localparam int CW = $clog2(DW);

    logic            r_busy, r_done, r_neg;
    logic [CW-1:0]   r_cnt;
    logic [DW-1:0]   r_q;
    logic [VW:0]     r_rem;
    logic [VW-1:0]   r_dv;
    logic [VW+1:0]   trial, dext;
    logic            fits;
    logic signed [DW-1:0]  neg_dvd;
    logic signed [VW:0]    neg_dvs;

    assign neg_dvd = -i_dividend;
    assign neg_dvs = -i_divisor;

    // Shift-subtract step
    assign trial = {r_rem, r_q[DW-1]};
    assign dext  = {2'b00, r_dv};
    assign fits  = (trial >= dext);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == CW'(DW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start && !r_busy) begin
            r_q   <= i_dividend[DW-1] ? DW'(neg_dvd) : DW'(i_dividend);
            r_dv  <= i_divisor[VW] ? neg_dvs[VW-1:0] : i_divisor[VW-1:0];
            r_rem <= '0;
            r_neg <= i_dividend[DW-1] ^ i_divisor[VW];
        end else if (r_busy) begin
            r_rem <= fits ? (VW+1)'(trial - dext) : trial[VW:0];
            r_q   <= {r_q[DW-2:0], fits};
        end
    end

    assign o_quot = r_neg ? -$signed({1'b0, r_q}) : $signed({1'b0, r_q});
    assign o_done = r_done;

endmodule

FILE: rtl/bearing_triangulation_average.sv
// An observation that is not last is accepted while the block is idle.
// A last observation starts the work: a 30-step CORDIC per stored bearing,
// then per bearing pair a parallel test and, for a used pair, two divisions
// on the shared divider, then the mean, by two divisions if any pair was used.
// Input stalls from a last transfer until its result is issued.
// Reset clears the control state and the count; stores need no clearing.
// ----------------------------------------------------------------------------
// bearing_triangulation_average
// Collects observer positions and bearings, intersects each non-parallel pair
// through a shared multiplier, divider and CORDIC, and reports the mean.
// ----------------------------------------------------------------------------
module bearing_triangulation_average #(
    parameter int MAX_BEARINGS = bta_pkg::MAX_BEARINGS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  bta_pkg::t_obs   i_in_data,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output bta_pkg::t_res   o_out_data,
    input  logic            i_cfg_valid,
    output logic            o_cfg_ready,
    input  logic [30:0]     i_cfg_data
);

    localparam int AW = $clog2(MAX_BEARINGS);
    localparam int CW = $clog2(MAX_BEARINGS + 1);
    localparam int PW = $clog2(MAX_BEARINGS * (MAX_BEARINGS - 1) / 2 + 1);
    localparam int SW = 32 + PW;
    localparam int DW = bta_pkg::DIR_W;

    localparam logic [4:0] S_IDLE  = 5'd0,  S_CR_RD = 5'd1,  S_CR_GO = 5'd2,
                           S_CR_WT = 5'd3,  S_PINIT = 5'd4,  S_PI_RD = 5'd5,
                           S_PJ_RD = 5'd6,  S_PJ_LD = 5'd7,  S_M1    = 5'd8,
                           S_M2    = 5'd9,  S_M3    = 5'd10, S_M4    = 5'd11,
                           S_M5    = 5'd12, S_M6    = 5'd13, S_M7    = 5'd14,
                           S_DX    = 5'd15, S_DY    = 5'd16, S_NEXT  = 5'd17,
                           S_MEAN  = 5'd18, S_MX    = 5'd19, S_MY    = 5'd20,
                           S_DONE  = 5'd21;

    localparam logic signed [68:0] QLIM = 69'sh0_0000_0002_0000_0000;

    logic [4:0]  r_state;
    logic [CW-1:0] r_cnt, r_n, r_k, r_i, r_j;
    logic [PW-1:0] r_pairs;
    logic [30:0] r_thr;
    logic signed [SW-1:0] r_sum_x, r_sum_y;
    logic signed [31:0]   r_ox, r_oy;
    logic        r_out_valid;
    bta_pkg::t_res r_out;

    // Observation and direction stores
    logic signed [31:0] x_mem [MAX_BEARINGS];
    logic signed [31:0] y_mem [MAX_BEARINGS];
    logic [15:0]        a_mem [MAX_BEARINGS];
    logic signed [DW-1:0] c_mem [MAX_BEARINGS];
    logic signed [DW-1:0] s_mem [MAX_BEARINGS];
    logic signed [31:0] r_rd_x, r_rd_y;
    logic [15:0]        r_rd_a;
    logic signed [DW-1:0] r_rd_c, r_rd_s;
    logic [AW-1:0]      rd_addr;

    // Pair operands and intermediates
    logic signed [31:0]   r_xi, r_yi, r_xj, r_yj;
    logic signed [DW-1:0] r_cxi, r_cyi, r_cxj, r_cyj;
    logic signed [37:0]   r_t;
    logic signed [32:0]   r_det;
    logic signed [34:0]   r_num;

    logic in_acc, room, out_free;
    logic [CW-1:0] n_cnt;

    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign room        = (r_cnt < CW'(MAX_BEARINGS));
    assign n_cnt       = r_cnt + CW'(room);
    assign out_free    = !r_out_valid || !i_out_stall;

    // Threshold register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= bta_pkg::THR_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_thr <= i_cfg_data;
        end
    end

    // Store write on each transfer that finds room
    always_ff @(posedge i_clk) begin
        if (in_acc && room) begin
            x_mem[r_cnt[AW-1:0]] <= i_in_data.pos_x;
            y_mem[r_cnt[AW-1:0]] <= i_in_data.pos_y;
            a_mem[r_cnt[AW-1:0]] <= i_in_data.bearing;
        end
    end

    // Registered store reads
    always_comb begin
        unique case (r_state)
            S_CR_RD: rd_addr = r_k[AW-1:0];
            S_PI_RD: rd_addr = r_i[AW-1:0];
            default: rd_addr = r_j[AW-1:0];
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_rd_x <= x_mem[rd_addr];
        r_rd_y <= y_mem[rd_addr];
        r_rd_a <= a_mem[rd_addr];
        r_rd_c <= c_mem[rd_addr];
        r_rd_s <= s_mem[rd_addr];
    end

    // CORDIC unit
    bta_pkg::t_unit_ctl crd_ctl;
    logic signed [DW-1:0] crd_cos, crd_sin;
    logic crd_done;

    assign crd_ctl.start = (r_state == S_CR_GO);
    assign crd_ctl.done  = 1'b0;

    bta_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (crd_ctl),
        .i_angle (r_rd_a),
        .o_done  (crd_done),
        .o_cos   (crd_cos),
        .o_sin   (crd_sin)
    );

    always_ff @(posedge i_clk) begin
        if (r_state == S_CR_WT && crd_done) begin
            c_mem[r_k[AW-1:0]] <= crd_cos;
            s_mem[r_k[AW-1:0]] <= crd_sin;
        end
    end

    // Shared multiplier operand select
    logic signed [bta_pkg::MUL_AW-1:0] mul_a;
    logic signed [bta_pkg::MUL_BW-1:0] mul_b;
    logic signed [bta_pkg::PROD_W-1:0] prod;
    logic signed [37:0] prod_sh;
    logic mul_en;

    always_comb begin
        mul_en = 1'b1;
        unique case (r_state)
            S_M1: begin
                mul_a = 36'(r_cxi);
                mul_b = 32'(r_cyj);
            end
            S_M2: begin
                mul_a = 36'(r_cyi);
                mul_b = 32'(r_cxj);
            end
            S_M3: begin
                mul_a = 36'(33'(r_xj) - 33'(r_xi));
                mul_b = 32'(r_cyj);
            end
            S_M4: begin
                mul_a = 36'(33'(r_yj) - 33'(r_yi));
                mul_b = 32'(r_cxj);
            end
            S_M6: begin
                mul_a = 36'(r_num);
                mul_b = 32'(r_cxi);
            end
            S_M7: begin
                mul_a = 36'(r_num);
                mul_b = 32'(r_cyi);
            end
            default: begin
                mul_en = 1'b0;
                mul_a  = '0;
                mul_b  = '0;
            end
        endcase
    end

    bta_mul u_mul (
        .i_clk (i_clk),
        .i_en  (mul_en),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (prod)
    );

    // Floor of product / 2^30
    assign prod_sh = prod[bta_pkg::PROD_W-1:30];

    // Shared divider
    bta_pkg::t_unit_ctl div_ctl;
    logic signed [bta_pkg::DVD_W-1:0] div_dvd;
    logic signed [bta_pkg::DVS_W-1:0] div_dvs;
    logic signed [bta_pkg::QUO_W-1:0] quot;
    logic div_done;
    logic mean_phase;

    assign mean_phase = (r_state == S_MEAN) || (r_state == S_MX);
    assign div_ctl.start = (r_state == S_M7) || (r_state == S_DX && div_done)
                         || (r_state == S_MEAN && r_pairs != '0)
                         || (r_state == S_MX && div_done);
    assign div_ctl.done  = 1'b0;

    always_comb begin
        if (mean_phase) begin
            div_dvd = (r_state == S_MEAN) ? bta_pkg::DVD_W'(r_sum_x)
                                          : bta_pkg::DVD_W'(r_sum_y);
            div_dvs = $signed(bta_pkg::DVS_W'(r_pairs));
        end else begin
            div_dvd = prod;
            div_dvs = r_det;
        end
    end

    bta_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (div_ctl),
        .i_dividend (div_dvd),
        .i_divisor  (div_dvs),
        .o_done     (div_done),
        .o_quot     (quot)
    );

    // Intersection: clamp offset, add origin, saturate to 32 bits
    logic signed [34:0] q_cl;
    logic signed [35:0] pos_sum;
    logic signed [31:0] pos_sat;
    logic signed [31:0] pos_org;

    assign pos_org = (r_state == S_DX) ? r_xi : r_yi;

    always_comb begin
        if (quot > QLIM)       q_cl = 35'(QLIM);
        else if (quot < -QLIM) q_cl = 35'(-QLIM);
        else                   q_cl = 35'(quot);
        pos_sum = 36'(q_cl) + 36'(pos_org);
        if (pos_sum > 36'sh07FFFFFFF)       pos_sat = 32'sh7FFFFFFF;
        else if (pos_sum < -36'sh080000000) pos_sat = 32'sh80000000;
        else                                pos_sat = 32'(pos_sum);
    end

    // Parallel test
    logic [31:0] det_mag;
    logic        skip;

    assign det_mag = r_det[32] ? 32'(-r_det) : 32'(r_det);
    assign skip    = (r_det == '0) || (det_mag < 32'(r_thr));

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        if (i_in_data.last) begin
                            r_n     <= n_cnt;
                            r_cnt   <= '0;
                            r_k     <= '0;
                            r_state <= S_CR_RD;
                        end else begin
                            r_cnt <= n_cnt;
                        end
                    end
                end
                S_CR_RD: begin
                    r_state <= (r_k == r_n) ? S_PINIT : S_CR_GO;
                end
                S_CR_GO: r_state <= S_CR_WT;
                S_CR_WT: begin
                    if (crd_done) begin
                        r_k     <= r_k + CW'(1);
                        r_state <= S_CR_RD;
                    end
                end
                S_PINIT: begin
                    r_i     <= '0;
                    r_j     <= CW'(1);
                    r_pairs <= '0;
                    r_sum_x <= '0;
                    r_sum_y <= '0;
                    r_state <= (r_n < CW'(2)) ? S_MEAN : S_PI_RD;
                end
                S_PI_RD: r_state <= S_PJ_RD;
                S_PJ_RD: begin
                    r_xi    <= r_rd_x;
                    r_yi    <= r_rd_y;
                    r_cxi   <= r_rd_c;
                    r_cyi   <= r_rd_s;
                    r_state <= S_PJ_LD;
                end
                S_PJ_LD: begin
                    r_xj    <= r_rd_x;
                    r_yj    <= r_rd_y;
                    r_cxj   <= r_rd_c;
                    r_cyj   <= r_rd_s;
                    r_state <= S_M1;
                end
                S_M1: r_state <= S_M2;
                S_M2: begin
                    r_t     <= prod_sh;
                    r_state <= S_M3;
                end
                S_M3: begin
                    r_det   <= 33'(r_t - prod_sh);
                    r_state <= S_M4;
                end
                S_M4: begin
                    r_t     <= prod_sh;
                    r_state <= skip ? S_NEXT : S_M5;
                end
                S_M5: begin
                    r_num   <= 35'(r_t - prod_sh);
                    r_state <= S_M6;
                end
                S_M6: r_state <= S_M7;
                S_M7: r_state <= S_DX;
                S_DX: begin
                    if (div_done) begin
                        r_sum_x <= r_sum_x + SW'(pos_sat);
                        r_state <= S_DY;
                    end
                end
                S_DY: begin
                    if (div_done) begin
                        r_sum_y <= r_sum_y + SW'(pos_sat);
                        r_pairs <= r_pairs + PW'(1);
                        r_state <= S_NEXT;
                    end
                end
                S_NEXT: begin
                    if (r_j + CW'(1) < r_n) begin
                        r_j     <= r_j + CW'(1);
                        r_state <= S_PI_RD;
                    end else if (r_i + CW'(2) < r_n) begin
                        r_i     <= r_i + CW'(1);
                        r_j     <= r_i + CW'(2);
                        r_state <= S_PI_RD;
                    end else begin
                        r_state <= S_MEAN;
                    end
                end
                S_MEAN: begin
                    if (r_pairs == '0) begin
                        r_ox    <= '0;
                        r_oy    <= '0;
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_MX;
                    end
                end
                S_MX: begin
                    if (div_done) begin
                        r_ox    <= quot[31:0];
                        r_state <= S_MY;
                    end
                end
                S_MY: begin
                    if (div_done) begin
                        r_oy    <= quot[31:0];
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && out_free) begin
            r_out.src_x      <= r_ox;
            r_out.src_y      <= r_oy;
            r_out.found      <= (r_pairs != '0);
            r_out.pair_count <= (32'(r_pairs) > 32'd127) ? 7'd127 : 7'(r_pairs);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Checks
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(MAX_BEARINGS))
        else $error("observation count beyond store depth");

    a_pair_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_M1) |-> (r_i < r_j && r_j < r_n))
        else $error("pair indices out of order");

    a_det_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_M7) |-> (r_det != '0))
        else $error("division by zero determinant");

    a_load_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_DONE))
        else $error("result issued outside completion");

    a_found_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.found == (o_out_data.pair_count != 7'd0)))
        else $error("found flag disagrees with pair count");

endmodule

FILE: test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Bearing triangulation testbench
// Drives sets of observations through the triangulation block, predicts each
// mean intersection with a cycle-free model kept in a small scoreboard, and
// compares every result transfer field by field. The parallel threshold is
// rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------
module testbench;

    localparam int  DEPTH    = bta_pkg::MAX_BEARINGS_DEF;
    localparam int  IDLE_PCT = 13;
    localparam longint ONE_Q30 = 64'sd1073741824;

    // Predicts the mean intersection of each closed set and holds the queue
    // of results still owed by the block.
    class triangulation_scoreboard;
        longint     obs_x[DEPTH];
        longint     obs_y[DEPTH];
        logic [15:0] obs_ang[DEPTH];
        int         n_obs;
        logic [30:0] threshold;
        bta_pkg::t_res pending[$];
        int         errors;

        function new();
            n_obs     = 0;
            threshold = bta_pkg::THR_RESET;
            errors    = 0;
        endfunction

        // Direction vector of a binary angle, Q2.30
        function void direction(input logic [15:0] ang, output longint c,
                                output longint s);
            logic [15:0] b;
            logic        flip;
            longint      x, y, z, nx;
            b    = ang;
            flip = (b[15:14] == 2'd1) || (b[15:14] == 2'd2);
            if (flip) b = b ^ 16'h8000;
            z = longint'($signed(b)) * 65536;
            x = bta_pkg::CORDIC_GAIN;
            y = 0;
            for (int i = 0; i < bta_pkg::CORDIC_STEPS; i++) begin
                if (z >= 0) begin
                    nx = x - (y >>> i);
                    y  = y + (x >>> i);
                    z  = z - longint'(bta_pkg::atan_turn(5'(i)));
                end else begin
                    nx = x + (y >>> i);
                    y  = y - (x >>> i);
                    z  = z + longint'(bta_pkg::atan_turn(5'(i)));
                end
                x = nx;
            end
            if (flip) begin
                x = -x;
                y = -y;
            end
            c = (x < -ONE_Q30) ? -ONE_Q30 : (x > ONE_Q30 ? ONE_Q30 : x);
            s = (y < -ONE_Q30) ? -ONE_Q30 : (y > ONE_Q30 ? ONE_Q30 : y);
        endfunction

        function longint clip(input longint v, input longint lo, input longint hi);
            return v < lo ? lo : (v > hi ? hi : v);
        endfunction

        // Offset along the first bearing line, wide enough not to wrap
        function longint offset(input longint num, input longint dir, input longint det);
            logic signed [95:0] w;
            w = num;
            w = w * dir;
            w = w / det;
            if (w < -96'sd8589934592) w = -96'sd8589934592;
            if (w > 96'sd8589934592)  w = 96'sd8589934592;
            return longint'(w);
        endfunction

        // An accepted observation; a last one closes the set
        function void note_obs(input bta_pkg::t_obs o);
            longint cx[DEPTH], cy[DEPTH];
            longint sum_x, sum_y, det, mag, a, b, num, ix, iy;
            int     pairs;
            bta_pkg::t_res r;
            if (n_obs < DEPTH) begin
                obs_x[n_obs]   = o.pos_x;
                obs_y[n_obs]   = o.pos_y;
                obs_ang[n_obs] = o.bearing;
                n_obs++;
            end
            if (!o.last) return;
            sum_x = 0;
            sum_y = 0;
            pairs = 0;
            for (int i = 0; i < n_obs; i++) direction(obs_ang[i], cx[i], cy[i]);
            for (int i = 0; i < n_obs; i++) begin
                for (int j = i + 1; j < n_obs; j++) begin
                    det = ((cx[i] * cy[j]) >>> 30) - ((cy[i] * cx[j]) >>> 30);
                    mag = det < 0 ? -det : det;
                    if (det == 0 || mag < longint'(threshold)) continue;
                    a   = obs_x[j] - obs_x[i];
                    b   = obs_y[j] - obs_y[i];
                    num = ((a * cy[j]) >>> 30) - ((b * cx[j]) >>> 30);
                    ix  = offset(num, cx[i], det) + obs_x[i];
                    iy  = offset(num, cy[i], det) + obs_y[i];
                    sum_x += clip(ix, -64'sd2147483648, 64'sd2147483647);
                    sum_y += clip(iy, -64'sd2147483648, 64'sd2147483647);
                    pairs++;
                end
            end
            n_obs = 0;
            r.src_x      = pairs > 0 ? 32'(sum_x / longint'(pairs)) : 32'sd0;
            r.src_y      = pairs > 0 ? 32'(sum_y / longint'(pairs)) : 32'sd0;
            r.found      = pairs > 0;
            r.pair_count = pairs > 127 ? 7'd127 : 7'(pairs);
            pending = {pending, r};
        endfunction

        // A result transfer against the oldest prediction
        function void check(input bta_pkg::t_res got);
            bta_pkg::t_res want;
            if (pending.size() == 0) begin
                $error("result transfer with no prediction waiting");
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.src_x !== want.src_x) begin
                $error("src_x expected %0d actual %0d", want.src_x, got.src_x);
                errors++;
            end
            if (got.src_y !== want.src_y) begin
                $error("src_y expected %0d actual %0d", want.src_y, got.src_y);
                errors++;
            end
            if (got.found !== want.found) begin
                $error("found expected %0d actual %0d", want.found, got.found);
                errors++;
            end
            if (got.pair_count !== want.pair_count) begin
                $error("pair_count expected %0d actual %0d", want.pair_count,
                       got.pair_count);
                errors++;
            end
        endfunction
    endclass

    logic          i_clk;
    logic          i_rst_n;
    logic          i_in_valid;
    logic          o_in_stall;
    bta_pkg::t_obs i_in_data;
    logic          o_out_valid;
    logic          i_out_stall;
    bta_pkg::t_res o_out_data;
    logic          i_cfg_valid;
    logic          o_cfg_ready;
    logic [30:0]   i_cfg_data;

    triangulation_scoreboard sb;
    logic quiet;
    logic [15:0] prev_ang;

    bearing_triangulation_average u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Result side: check each transfer, stall at random
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) sb.check(o_out_data);
        i_out_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PCT);
    end

    // One observation transfer, with random idle cycles ahead of it
    task automatic send_obs(input bta_pkg::t_obs o);
        while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= o;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_obs(o);
    endtask

    // Threshold write, only once every result is in and the block is idle
    task automatic write_threshold(input logic [30:0] thr);
        i_in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= thr;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.threshold = thr;
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] rand_pos();
        if ($urandom_range(0, 9) == 0) return $urandom;
        return 32'($signed($urandom_range(0, 32'hFFFFFF)) - 32'sh800000);
    endfunction

    // Bearings: mostly random, some axis-aligned, some parallel to the last
    function automatic logic [15:0] rand_ang();
        case ($urandom_range(0, 9))
            0:       return 16'($urandom_range(0, 3) * 16384);
            1:       return 16'hFFFF;
            2:       return prev_ang;
            3:       return prev_ang ^ 16'h8000;
            default: return 16'($urandom);
        endcase
    endfunction

    // One set of n observations with random content
    task automatic random_set(input int n);
        bta_pkg::t_obs o;
        for (int k = 0; k < n; k++) begin
            o.pos_x   = rand_pos();
            o.pos_y   = rand_pos();
            o.bearing = rand_ang();
            o.last    = (k == n - 1);
            prev_ang  = o.bearing;
            send_obs(o);
        end
    endtask

    // Random sets, mostly small, now and then over capacity
    task automatic random_phase(input int items);
        int sent, n;
        sent = 0;
        while (sent < items) begin
            n = ($urandom_range(0, 19) == 0) ? $urandom_range(14, 20)
                                             : $urandom_range(1, 6);
            random_set(n);
            sent += n;
        end
    endtask

    task automatic directed_obs(input logic [31:0] x, input logic [31:0] y,
                                input logic [15:0] ang, input logic last);
        bta_pkg::t_obs o;
        o.pos_x   = x;
        o.pos_y   = y;
        o.bearing = ang;
        o.last    = last;
        send_obs(o);
    endtask

    initial begin
        sb          = new();
        quiet       = 1'b0;
        prev_ang    = 16'd0;
        i_clk       = 1'b0;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_out_stall = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: zero threshold, so only exact parallels are skipped
        write_threshold(31'd0);
        // lone observation
        directed_obs(32'h7FFFFFFF, 32'h80000000, 16'd0, 1'b1);
        // identical bearings: exactly parallel
        directed_obs(32'h00010000, 32'h0, 16'd16384, 1'b0);
        directed_obs(32'h00050000, 32'h0, 16'd16384, 1'b1);
        // opposite bearings
        directed_obs(32'h0, 32'h0, 16'd0, 1'b0);
        directed_obs(32'h0, 32'h00020000, 16'd32768, 1'b1);
        // extreme positions, crossing lines, saturated coordinates
        directed_obs(32'h7FFFFFFF, 32'h7FFFFFFF, 16'd49152, 1'b0);
        directed_obs(32'h80000000, 32'h80000000, 16'hFFFF, 1'b1);
        directed_obs(32'h80000000, 32'h7FFFFFFF, 16'd8192, 1'b0);
        directed_obs(32'h7FFFFFFF, 32'h80000000, 16'd24576, 1'b1);
        // full store: the last observation is dropped yet closes the set
        for (int k = 0; k < 17; k++)
            directed_obs(32'(k * 32'h00030000), 32'(k * 32'hFFFF0000),
                         16'(k * 4099), k == 16);

        write_threshold(bta_pkg::THR_RESET);
        quiet = 1'b1;
        random_phase(80);
        quiet = 1'b0;
        random_phase(100);
        write_threshold(31'd1073741824);
        random_phase(80);
        write_threshold(31'($urandom_range(0, 1073741824)));
        random_phase(120);
        write_threshold(31'($urandom_range(0, 65536)));
        random_phase(100);

        i_in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Run limit
    initial begin
        #50_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/bta_pkg.sv
rtl/bta_cordic.sv
rtl/bta_mul.sv
rtl/bta_div.sv
rtl/bearing_triangulation_average.sv
test/testbench.sv
